/* hdl/csb_pkg.sv */
// shared constants, register codes and config types for the color-keyed sprite blitter
package csb_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int PIXEL_BITS = 16;
  localparam int DIM_BITS   = $clog2(MAX_DIM) + 1;      // holds 0..MAX_DIM and raw 12-bit fields
  localparam int CNT_BITS   = $clog2(MAX_DIM);          // counters stay below MAX_DIM
  localparam int POS_BITS   = DIM_BITS + 2;             // signed screen position
  localparam int ADDR_BITS  = 2 * CNT_BITS;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [DIM_BITS-1:0]   SCREEN_W_RESET = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]   SCREEN_H_RESET = DIM_BITS'(768);
  localparam logic [DIM_BITS-1:0]   SPRITE_W_RESET = DIM_BITS'(64);
  localparam logic [DIM_BITS-1:0]   SPRITE_H_RESET = DIM_BITS'(64);
  localparam logic [PIXEL_BITS-1:0] KEY_RESET      = PIXEL_BITS'(16'hF81F);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_KEY_COLOR     = 3'd6,
    REG_KEY_ENABLE    = 3'd7
  } cfg_reg_t;

  // effective configuration, with the screen and sprite sizes clamped
  typedef struct packed {
    logic [DIM_BITS-1:0]        screen_w;
    logic [DIM_BITS-1:0]        screen_h;
    logic [DIM_BITS-1:0]        sprite_w;
    logic [DIM_BITS-1:0]        sprite_h;
    logic signed [DIM_BITS-1:0] origin_x;
    logic signed [DIM_BITS-1:0] origin_y;
    logic [PIXEL_BITS-1:0]      key_color;
    logic                       key_enable;
  } cfg_t;

  function automatic logic [DIM_BITS-1:0] clamp_screen(input logic [DIM_BITS-1:0] v);
    if (v > DIM_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [DIM_BITS-1:0] clamp_sprite(input logic [DIM_BITS-1:0] v);
    if (v == '0) return DIM_BITS'(1);
    if (v > DIM_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
    return v;
  endfunction

endpackage

/* hdl/csb_pixel_if.sv */
// sprite pixel input channel
interface csb_pixel_if
  import csb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

/* hdl/csb_write_if.sv */
// frame buffer write output channel
interface csb_write_if
  import csb_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ADDR_BITS-1:0]  fb_address;
  logic [PIXEL_BITS-1:0] fb_data;

  modport source (output valid, output fb_address, output fb_data, input ready);
  modport sink   (input valid, input fb_address, input fb_data, output ready);
endinterface

/* hdl/csb_cfg.sv */
// configuration registers with clamping of the geometry values
module csb_cfg
  import csb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  logic [DIM_BITS-1:0]   screen_w;
  logic [DIM_BITS-1:0]   screen_h;
  logic [DIM_BITS-1:0]   sprite_w;
  logic [DIM_BITS-1:0]   sprite_h;
  logic [DIM_BITS-1:0]   origin_x;
  logic [DIM_BITS-1:0]   origin_y;
  logic [PIXEL_BITS-1:0] key_color;
  logic                  key_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w   <= SCREEN_W_RESET;
      screen_h   <= SCREEN_H_RESET;
      sprite_w   <= SPRITE_W_RESET;
      sprite_h   <= SPRITE_H_RESET;
      origin_x   <= '0;
      origin_y   <= '0;
      key_color  <= KEY_RESET;
      key_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_w   <= cfg_data[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_h   <= cfg_data[DIM_BITS-1:0];
        REG_SPRITE_WIDTH:  sprite_w   <= cfg_data[DIM_BITS-1:0];
        REG_SPRITE_HEIGHT: sprite_h   <= cfg_data[DIM_BITS-1:0];
        REG_ORIGIN_X:      origin_x   <= cfg_data[DIM_BITS-1:0];
        REG_ORIGIN_Y:      origin_y   <= cfg_data[DIM_BITS-1:0];
        REG_KEY_COLOR:     key_color  <= cfg_data[PIXEL_BITS-1:0];
        REG_KEY_ENABLE:    key_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.screen_w   = clamp_screen(screen_w);
    cfg.screen_h   = clamp_screen(screen_h);
    cfg.sprite_w   = clamp_sprite(sprite_w);
    cfg.sprite_h   = clamp_sprite(sprite_h);
    cfg.origin_x   = $signed(origin_x);
    cfg.origin_y   = $signed(origin_y);
    cfg.key_color  = key_color;
    cfg.key_enable = key_enable;
  end

endmodule

/* hdl/color_keyed_sprite_blitter_top.sv */
// top level of the color-keyed sprite blitter
//
// Sprite pixels arrive on the pixel channel in stored order: rows bottom-up,
// pixels in a row left to right. Each accepted pixel advances a column and
// row counter that wrap after sprite width times height pixels; stored row r
// lands on screen row origin_y + height - 1 - r. A pixel that is on screen
// and, with keying on, not the key color produces one transfer on fb_write
// carrying the frame buffer index (column + row * screen width) and the pixel.
// Others produce nothing.
// A pixel is registered in the first stage (position and clip); the row times
// pitch multiply of the second stage feeds the output register on fb_write.
// Throughput: one pixel per cycle, sustained while fb_write is ready.
// A stall on fb_write holds the output register; the first stage keeps taking
// pixels until it holds one that writes, then pixel.ready drops until the
// output moves.
// Registers are written on cfg_wr_en at cfg_index. The user must write them
// only while no pixel is in flight; the block does not enforce it.
// Reset (synchronous) restores the register defaults, zeroes both counters
// and empties the pipeline.
module color_keyed_sprite_blitter_top
  import csb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  csb_pixel_if.sink                pixel,
  csb_write_if.source              fb_write,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  csb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [CNT_BITS-1:0] column_count, column_count_next;
  logic [CNT_BITS-1:0] row_count, row_count_next;

  logic                  s1_valid;
  logic [CNT_BITS-1:0]   s1_x;
  logic [CNT_BITS-1:0]   s1_y;
  logic [PIXEL_BITS-1:0] s1_pixel;

  logic                  out_valid;
  logic [ADDR_BITS-1:0]  out_address;
  logic [PIXEL_BITS-1:0] out_data;

  logic advance;
  logic take;

  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic                       visible;
  logic                       keyed;

  logic [DIM_BITS:0]            col_inc;
  logic [DIM_BITS:0]            row_inc;
  logic [CNT_BITS+DIM_BITS-1:0] row_offset;
  logic [CNT_BITS+DIM_BITS-1:0] addr_full;

  assign advance     = !out_valid || fb_write.ready;
  assign take        = pixel.valid && pixel.ready;
  assign pixel.ready = !s1_valid || advance;

  // screen position of the current pixel
  always_comb begin
    pos_x = POS_BITS'(cfg.origin_x) + $signed({{(POS_BITS-CNT_BITS){1'b0}}, column_count});
    pos_y = POS_BITS'(cfg.origin_y) + $signed({{(POS_BITS-DIM_BITS){1'b0}}, cfg.sprite_h})
          - POS_BITS'(1) - $signed({{(POS_BITS-CNT_BITS){1'b0}}, row_count});
    visible = !pos_x[POS_BITS-1] && !pos_y[POS_BITS-1]
           && (pos_x[POS_BITS-2:0] < {1'b0, cfg.screen_w})
           && (pos_y[POS_BITS-2:0] < {1'b0, cfg.screen_h});
    keyed = cfg.key_enable && (pixel.pixel_value == cfg.key_color);
  end

  // counter wrap
  always_comb begin
    col_inc = {{(DIM_BITS+1-CNT_BITS){1'b0}}, column_count} + (DIM_BITS+1)'(1);
    row_inc = {{(DIM_BITS+1-CNT_BITS){1'b0}}, row_count} + (DIM_BITS+1)'(1);
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_inc >= {1'b0, cfg.sprite_w}) begin
      column_count_next = '0;
      if (row_inc >= {1'b0, cfg.sprite_h}) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[CNT_BITS-1:0];
      end
    end else begin
      column_count_next = col_inc[CNT_BITS-1:0];
      if ({{(DIM_BITS-CNT_BITS){1'b0}}, row_count} >= cfg.sprite_h) begin
        row_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      s1_valid     <= visible && !keyed;
    end else if (advance) begin
      s1_valid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x     <= pos_x[CNT_BITS-1:0];
      s1_y     <= pos_y[CNT_BITS-1:0];
      s1_pixel <= pixel.pixel_value;
    end
  end

  // row times pitch plus column
  always_comb begin
    row_offset = {{DIM_BITS{1'b0}}, s1_y} * {{CNT_BITS{1'b0}}, cfg.screen_w};
    addr_full  = row_offset + {{DIM_BITS{1'b0}}, s1_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_address <= addr_full[ADDR_BITS-1:0];
      out_data    <= s1_pixel;
    end
  end

  assign fb_write.valid      = out_valid;
  assign fb_write.fb_address = out_address;
  assign fb_write.fb_data    = out_data;

endmodule

/* tb/color_keyed_sprite_blitter_top_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench: directed and random sprite pixels checked against a write predictor
module color_keyed_sprite_blitter_top_tb;
  import csb_pkg::*;

  localparam int RANDOM_PIXELS = 1650;
  localparam int MAX_WAIT      = 11;
  localparam int DRAIN_CYCLES  = 5;
  localparam int QUIET_LIMIT   = 1000;
  localparam int RAW_DIM_MAX   = (1 << DIM_BITS) - 1;

  typedef enum bit {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 reg_sel;
    logic [CFG_DATA_BITS-1:0] value;
    bit                       typed;
    bit                       typed_hit;
    logic [ADDR_BITS-1:0]     typed_addr;
  } dir_row_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] data;
  } fb_write_t;

  localparam int DIR_ROWS = 34;

  // pixel rows with typed results are checked against the typed value, the rest
  // against the predictor
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h0000, 1'b1, 1'b1, 22'd64512},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hF81F, 1'b1, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hFFFF, 1'b1, 1'b1, 22'd64514},
    '{ROW_CONFIG, REG_SPRITE_WIDTH,  16'h0002, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SPRITE_HEIGHT, 16'h0002, 1'b0, 1'b0, 22'd0},
    // counters now lie outside the shrunken sprite
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h1234, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hF81F, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_KEY_ENABLE,    16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hF81F, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_KEY_COLOR,     16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_KEY_ENABLE,    16'hFFFF, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h0001, 1'b0, 1'b0, 22'd0},
    // zero screen width hides everything
    '{ROW_CONFIG, REG_SCREEN_WIDTH,  16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hABCD, 1'b1, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h5555, 1'b1, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SCREEN_WIDTH,  16'h0FFF, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SCREEN_HEIGHT, 16'h0800, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SPRITE_WIDTH,  16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SPRITE_HEIGHT, 16'h0000, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_ORIGIN_X,      16'h07FF, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_ORIGIN_Y,      16'h07FF, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h8000, 1'b0, 1'b0, 22'd0},
    // bottom right corner of the largest screen
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h7FFF, 1'b1, 1'b1, 22'd4194303},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h7FFE, 1'b1, 1'b1, 22'd4194303},
    '{ROW_CONFIG, REG_ORIGIN_X,      16'h0800, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_ORIGIN_Y,      16'h0800, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h00FF, 1'b1, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SPRITE_WIDTH,  16'h0FFF, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_SPRITE_HEIGHT, 16'h0800, 1'b0, 1'b0, 22'd0},
    // upper data bits are dropped
    '{ROW_CONFIG, REG_ORIGIN_X,      16'hF000, 1'b0, 1'b0, 22'd0},
    '{ROW_CONFIG, REG_ORIGIN_Y,      16'hF801, 1'b0, 1'b0, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'h0F0F, 1'b1, 1'b1, 22'd0},
    '{ROW_PIXEL,  REG_SCREEN_WIDTH,  16'hF0F0, 1'b0, 1'b0, 22'd0}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  cfg_reg_t                 cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  csb_pixel_if pixel_ch ();
  csb_write_if fb_ch ();

  color_keyed_sprite_blitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel_ch),
    .fb_write (fb_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the registers and counters
  logic [DIM_BITS-1:0]        scr_w, scr_h, spr_w, spr_h;
  logic signed [DIM_BITS-1:0] org_x, org_y;
  logic [PIXEL_BITS-1:0]      key_col;
  logic                       key_en;
  int                         col_cnt, row_cnt;

  fb_write_t pending_writes[$];
  int        errors;
  int        pixels_sent;
  int        tx_max_gap;
  int        rx_max_stall;
  int        stall_left;
  int        quiet_cycles;

  always #1 clk = ~clk;

  function automatic void reset_model();
    scr_w   = SCREEN_W_RESET;
    scr_h   = SCREEN_H_RESET;
    spr_w   = SPRITE_W_RESET;
    spr_h   = SPRITE_H_RESET;
    org_x   = '0;
    org_y   = '0;
    key_col = KEY_RESET;
    key_en  = 1'b1;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function automatic void apply_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] d);
    case (r)
      REG_SCREEN_WIDTH:  scr_w   = d[DIM_BITS-1:0];
      REG_SCREEN_HEIGHT: scr_h   = d[DIM_BITS-1:0];
      REG_SPRITE_WIDTH:  spr_w   = d[DIM_BITS-1:0];
      REG_SPRITE_HEIGHT: spr_h   = d[DIM_BITS-1:0];
      REG_ORIGIN_X:      org_x   = d[DIM_BITS-1:0];
      REG_ORIGIN_Y:      org_y   = d[DIM_BITS-1:0];
      REG_KEY_COLOR:     key_col = d[PIXEL_BITS-1:0];
      REG_KEY_ENABLE:    key_en  = d[0];
      default: ;
    endcase
  endfunction

  // places one pixel, returns whether it is written, and advances the counters
  function automatic bit blit_step(input logic [PIXEL_BITS-1:0] pix,
                                   output logic [ADDR_BITS-1:0] addr);
    int sw, sh, w, h, sx, sy;
    bit hit;
    sw = (scr_w > MAX_DIM) ? MAX_DIM : int'(scr_w);
    sh = (scr_h > MAX_DIM) ? MAX_DIM : int'(scr_h);
    w  = (spr_w == 0) ? 1 : ((spr_w > MAX_DIM) ? MAX_DIM : int'(spr_w));
    h  = (spr_h == 0) ? 1 : ((spr_h > MAX_DIM) ? MAX_DIM : int'(spr_h));
    sx = int'(org_x) + col_cnt;
    // bottom-up storage: stored row 0 is the lowest screen row
    sy = int'(org_y) + h - 1 - row_cnt;
    hit = sx >= 0 && sy >= 0 && sx < sw && sy < sh && !(key_en && pix == key_col);
    addr = ADDR_BITS'(sx + sy * sw);
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end else if (row_cnt >= h) begin
      row_cnt = 0;
    end
    return hit;
  endfunction

  function automatic int pick_dim_extreme();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      3: return RAW_DIM_MAX;
      default: return $urandom_range(2, RAW_DIM_MAX);
    endcase
  endfunction

  function automatic int pick_origin_extreme();
    case ($urandom_range(0, 3))
      0: return -MAX_DIM;
      1: return MAX_DIM - 1;
      2: return -1;
      default: return $urandom_range(0, RAW_DIM_MAX);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit use_typed,
                            input bit typed_hit, input logic [ADDR_BITS-1:0] typed_addr);
    int gap;
    bit hit;
    logic [ADDR_BITS-1:0] addr;
    fb_write_t wr;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.pixel_value <= pix;
    do @(posedge clk); while (!pixel_ch.ready);
    hit = blit_step(pix, addr);
    if (use_typed) begin
      hit  = typed_hit;
      addr = typed_addr;
    end
    if (hit) begin
      wr.addr = addr;
      wr.data = pix;
      pending_writes.push_back(wr);
    end
    pixels_sent++;
  endtask

  // pipeline holds nothing once every write is back and the DRAIN_CYCLES wait is over
  task automatic wait_idle();
    @(negedge clk);
    pixel_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    apply_reg(r, d);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input bit all_regs);
    int sw, sh, w, h, ox, oy, count;
    bit extreme;
    logic [PIXEL_BITS-1:0] key, pix;
    extreme = ($urandom_range(0, 7) == 0);
    if (extreme) begin
      sw = pick_dim_extreme();
      sh = pick_dim_extreme();
      w  = pick_dim_extreme();
      h  = pick_dim_extreme();
      ox = pick_origin_extreme();
      oy = pick_origin_extreme();
      count = $urandom_range(1, 40);
    end else begin
      // small screen so that clipping happens on every edge
      sw = $urandom_range(1, 40);
      sh = $urandom_range(1, 40);
      w  = $urandom_range(1, 8);
      h  = $urandom_range(1, 8);
      ox = int'($urandom_range(0, sw + w + 4)) - w - 2;
      oy = int'($urandom_range(0, sh + h + 4)) - h - 2;
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30)
                                          : w * h * $urandom_range(1, 3);
    end
    case ($urandom_range(0, 3))
      0: key = KEY_RESET;
      1: key = '0;
      default: key = PIXEL_BITS'($urandom);
    endcase
    wait_idle();
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_SCREEN_WIDTH, {4'($urandom), 12'(sw)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_SCREEN_HEIGHT, {4'($urandom), 12'(sh)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_SPRITE_WIDTH, {4'($urandom), 12'(w)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_SPRITE_HEIGHT, {4'($urandom), 12'(h)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_ORIGIN_X, {4'($urandom), 12'(ox)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_ORIGIN_Y, {4'($urandom), 12'(oy)});
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_KEY_COLOR, key);
    if (all_regs || extreme || $urandom_range(0, 4) != 0)
      write_reg(REG_KEY_ENABLE, {15'($urandom), 1'($urandom_range(0, 4) != 0)});
    close_cfg();
    tx_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
    rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
    for (int n = 0; n < count; n++) begin
      pix = ($urandom_range(0, 3) == 0) ? key_col : PIXEL_BITS'($urandom);
      send_pixel(pix, 1'b0, 1'b0, '0);
    end
  endtask

  // write sink: random stall after each transfer
  always @(negedge clk) begin
    if (rst) begin
      fb_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      fb_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      fb_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_writes
    fb_write_t want;
    if (!rst && fb_ch.valid && fb_ch.ready) begin
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write, expected none, got addr %0d data %h",
                 $time, fb_ch.fb_address, fb_ch.fb_data);
      end else begin
        want = pending_writes.pop_front();
        if (fb_ch.fb_address !== want.addr) begin
          errors++;
          $display("%0t: fb_address expected %0d, got %0d",
                   $time, want.addr, fb_ch.fb_address);
        end
        if (fb_ch.fb_data !== want.data) begin
          errors++;
          $display("%0t: fb_data expected %h, got %h", $time, want.data, fb_ch.fb_data);
        end
      end
      stall_left = $urandom_range(0, rx_max_stall);
    end
  end

  always @(posedge clk) begin
    if ((pixel_ch.valid && pixel_ch.ready) || (fb_ch.valid && fb_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("color_keyed_sprite_blitter_top_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int start_count;
    bit cfg_open;
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_index            = REG_SCREEN_WIDTH;
    cfg_data             = '0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.pixel_value = '0;
    fb_ch.ready          = 1'b0;
    errors       = 0;
    pixels_sent  = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    tx_max_gap   = MAX_WAIT;
    rx_max_stall = MAX_WAIT;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CONFIG) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        if (cfg_open) begin
          close_cfg();
          cfg_open = 1'b0;
        end
        send_pixel(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].typed_hit,
                   dir_tab[i].typed_addr);
      end
    end

    start_count = pixels_sent;
    run_phase(1'b1);
    while (pixels_sent - start_count < RANDOM_PIXELS) run_phase(1'b0);
    wait_idle();

    if (errors == 0)
      $display("color_keyed_sprite_blitter_top_tb passed");
    else
      $display("color_keyed_sprite_blitter_top_tb failed");
    $finish;
  end

endmodule
